[rtl/rfdc_pkg.sv]
// ----------------------------------------------------------------------------
// rfdc_pkg
// Types, codes and constants shared by the receive-frame deframer files.
// ----------------------------------------------------------------------------
package rfdc_pkg;

    // Frame parser phases. The one unused 3-bit code falls into the default arm.
    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_FUNC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5,
        PH_STOP  = 3'd6
    } t_phase;

    // Frame status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_STOP_ERR = 2'd1,
        ST_SUM_ERR  = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam int CfgIdxW = 2;
    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_ONE = 2'd0,
        CFG_START_TWO = 2'd1,
        CFG_STOP      = 2'd2
    } t_cfg_idx;

    localparam int ByteW        = 8;
    localparam int WordW        = 16;
    localparam int FrameLenW    = 9;
    localparam int FrameOverhead = 6;
    localparam int OutDataW     = 64;

    // Register values handed to the parser.
    typedef struct packed {
        logic [ByteW-1:0] start_one;
        logic [ByteW-1:0] start_two;
        logic [ByteW-1:0] stop_val;
    } t_cfg;

    // One decoded frame result.
    typedef struct packed {
        t_status              status;
        logic [ByteW-1:0]     func;
        logic [ByteW-1:0]     len;
        logic [FrameLenW-1:0] frame_len;
        logic [WordW-1:0]     first_word;
        logic [WordW-1:0]     second_word;
    } t_result;

endpackage

[rtl/rfdc_engine.sv]
// ----------------------------------------------------------------------------
// rfdc_engine
// Byte-wise frame parser: start byte hunt, header capture, running checksum,
// data word capture and the final status decision at the stop byte.
// ----------------------------------------------------------------------------
module rfdc_engine
    import rfdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,        // one byte is processed this cycle
    input  logic [ByteW-1:0] i_byte,
    input  t_cfg             i_cfg,
    output logic             o_stop_phase,  // the next byte closes a frame
    output t_result          o_res          // valid when i_step and o_stop_phase
);

    t_phase           r_phase,     n_phase;
    logic [ByteW-1:0] r_sum,       n_sum;
    logic [ByteW-1:0] r_left,      n_left;
    logic [ByteW-1:0] r_len,       n_len;
    logic [ByteW-1:0] r_func,      n_func;
    logic [WordW-1:0] r_word0,     n_word0;
    logic [WordW-1:0] r_word1,     n_word1;
    logic             r_sum_ok,    n_sum_ok;

    logic [ByteW-1:0] w_idx;

    assign o_stop_phase = (r_phase == PH_STOP);
    assign w_idx        = r_len - r_left;

    // Result fields come straight from the held header and words.
    always_comb begin
        o_res.func        = r_func;
        o_res.len         = r_len;
        o_res.frame_len   = {1'b0, r_len} + FrameLenW'(FrameOverhead);
        o_res.first_word  = r_word0;
        o_res.second_word = r_word1;
        if (i_byte != i_cfg.stop_val) begin
            o_res.status = ST_STOP_ERR;
        end else if (!r_sum_ok) begin
            o_res.status = ST_SUM_ERR;
        end else begin
            o_res.status = ST_OK;
        end
    end

    // Next-state logic for one byte.
    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_left   = r_left;
        n_len    = r_len;
        n_func   = r_func;
        n_word0  = r_word0;
        n_word1  = r_word1;
        n_sum_ok = r_sum_ok;
        if (i_step) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (i_byte == i_cfg.start_two) begin
                        n_phase = PH_FUNC;
                    end else if (i_byte != i_cfg.start_one) begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_FUNC: begin
                    n_func  = i_byte;
                    n_sum   = i_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    n_left  = i_byte;
                    n_sum   = r_sum + i_byte;
                    n_word0 = '0;
                    n_word1 = '0;
                    n_phase = (i_byte != '0) ? PH_DATA : PH_CSUM;
                end
                PH_DATA: begin
                    n_sum  = r_sum + i_byte;
                    n_left = r_left - 1'b1;
                    // Only bytes 0-1, and 2-3 when len is 3 or 4, are kept.
                    if (w_idx == 8'd0) begin
                        n_word0 = {i_byte, 8'h00};
                    end else if (w_idx == 8'd1) begin
                        n_word0 = {r_word0[WordW-1:ByteW], i_byte};
                    end else if (w_idx == 8'd2) begin
                        if (r_len == 8'd3) begin
                            n_word1 = {8'h00, i_byte};
                        end else if (r_len == 8'd4) begin
                            n_word1 = {i_byte, 8'h00};
                        end
                    end else if (w_idx == 8'd3) begin
                        if (r_len == 8'd4) begin
                            n_word1 = {r_word1[WordW-1:ByteW], i_byte};
                        end
                    end
                    if (r_left == 8'd1) begin
                        n_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    n_sum_ok = (i_byte == r_sum);
                    n_phase  = PH_STOP;
                end
                PH_STOP: begin
                    n_phase = PH_HUNT1;
                end
                default: begin
                    n_phase = (i_byte == i_cfg.start_one) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT1;
            r_sum    <= '0;
            r_left   <= '0;
            r_len    <= '0;
            r_func   <= '0;
            r_word0  <= '0;
            r_word1  <= '0;
            r_sum_ok <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_left   <= n_left;
            r_len    <= n_len;
            r_func   <= n_func;
            r_word0  <= n_word0;
            r_word1  <= n_word1;
            r_sum_ok <= n_sum_ok;
        end
    end

    // A data phase always has bytes left to take.
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_left != '0))
        else $error("data phase with no bytes left");

    // The checksum byte always leads to the stop byte.
    a_csum_to_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_CSUM) |=> (r_phase == PH_STOP))
        else $error("checksum byte did not lead to stop phase");

    // After a frame closes the parser hunts again.
    a_stop_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_STOP) |=> (r_phase == PH_HUNT1))
        else $error("parser did not return to hunting after a frame");

endmodule

[rtl/rx_frame_deframer_checksum.sv]
// ----------------------------------------------------------------------------
// rx_frame_deframer_checksum
// Receive-frame deframer with an additive 8-bit checksum and stop byte check.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                          Payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  rx_byte, 8 bits
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  frame result, 59 bits in 64
//  cfg       in         i_cfg_valid/o_cfg_ready           index 2 bits, data 8 bits
//
//  One byte is taken per cycle unless a stop byte waits on a stalled output; a
//  byte sits in the input register while the parser works on it, and a result
//  is loaded into the output register when the parser takes the stop byte.
//  A stop byte passes the input register and the parser before its result is registered.
//  Reset is synchronous and active low; it clears the parser to start-byte
//  hunting and the valid flags and configuration to zero; data registers are not reset.
//  A stalled output only holds back a stop byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module rx_frame_deframer_checksum
    import rfdc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [ByteW-1:0]    i_s_axis_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OutDataW-1:0] o_m_axis_tdata,   // [1:0] frame_status,
                                                  // [9:2] function_code,
                                                  // [17:10] payload_length,
                                                  // [26:18] frame_length,
                                                  // [42:27] first_word,
                                                  // [58:43] second_word,
                                                  // [63:59] zero
    // Configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [ByteW-1:0]    i_cfg_data
);

    logic             r_in_vld;
    logic [ByteW-1:0] r_in_byte;
    logic             r_out_vld;
    t_result          r_out;
    t_cfg             r_cfg;

    logic             w_stop_phase;
    logic             w_step;
    logic             w_res_vld;
    t_result          w_res;

    // A byte moves into the parser unless it closes a frame and the
    // output register still holds an untaken result.
    assign w_step          = r_in_vld && (!w_stop_phase || !r_out_vld || i_m_axis_tready);
    assign w_res_vld       = w_step && w_stop_phase;
    assign o_s_axis_tready = !r_in_vld || w_step;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_ONE: r_cfg.start_one <= i_cfg_data;
                CFG_START_TWO: r_cfg.start_two <= i_cfg_data;
                CFG_STOP:      r_cfg.stop_val  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    rfdc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_byte       (r_in_byte),
        .i_cfg        (r_cfg),
        .o_stop_phase (w_stop_phase),
        .o_res        (w_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out.second_word, r_out.first_word,
                              r_out.frame_len, r_out.len, r_out.func, r_out.status};

    // A new result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> (!r_out_vld || i_m_axis_tready))
        else $error("result overwritten before transfer");

    // A result shows up only after a stop byte went through the parser.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_res_vld))
        else $error("result valid without a closing byte");

    // A byte held in the input register stays put until it is processed.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_step) |=> (r_in_vld && $stable(r_in_byte)))
        else $error("pending input byte lost");

endmodule
